### hdl/sfg_pkg.sv
`default_nettype none

package sfg_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_UP_THRESHOLD      = 2'd0;
   localparam logic [1:0] CSR_DOWN_THRESHOLD    = 2'd1;
   localparam logic [1:0] CSR_UP_STEP_PERCENT   = 2'd2;
   localparam logic [1:0] CSR_DOWN_STEP_PERCENT = 2'd3;

   localparam logic [6:0] RST_UP_THRESHOLD      = 7'd80;
   localparam logic [6:0] RST_DOWN_THRESHOLD    = 7'd35;
   localparam logic [6:0] RST_UP_STEP_PERCENT   = 7'd25;
   localparam logic [6:0] RST_DOWN_STEP_PERCENT = 7'd5;

   // x / 100 is computed as (x / 4) / 25 with a reciprocal of 25 scaled by 2^34.
   // The scaled reciprocal is rounded up and is exact for dividends below 2^29.
   localparam int          DIV25_SHIFT = 34;
   localparam logic [29:0] DIV25_MAGIC = 30'd687194768;

   typedef struct packed {
      logic [6:0]  load_percent;
      logic [23:0] freq_min;
      logic [23:0] freq_max;
      logic [23:0] freq_now;
   } req_type;

   typedef struct packed {
      logic [23:0] target_freq;
      logic        round_up;
   } rsp_type;

   // Everything the state update needs for one item, with the steps already scaled.
   typedef struct packed {
      logic        step_up;
      logic        step_down;
      logic [23:0] freq_min;
      logic [23:0] freq_max;
      logic [23:0] freq_now;
      logic [24:0] up_step;
      logic [24:0] down_step;
      logic [17:0] max_step;
   } step_type;

   // Floor of x / 100 for any 31-bit x.
   function automatic logic [24:0] div100(input logic [30:0] x);
      logic [58:0] prod;
      prod = {30'd0, x[30:2]} * {29'd0, DIV25_MAGIC};
      return prod[58:DIV25_SHIFT];
   endfunction

endpackage

`default_nettype wire

### hdl/step_frequency_governor_unit.sv
`default_nettype none

// Step frequency governor. Each item on the req_ channel is one sampling tick carrying the
// measured load and the policy minimum, maximum and current frequency. High load steps the
// remembered request up by a percentage of the maximum, low load steps it down; each step
// is clamped to the policy range and sent on the rsp_ channel with its rounding relation.
// Moderate load produces no item on rsp_ and leaves the remembered request alone.
// An accepted item passes through an input register, a register after the percent products,
// a register after the divide-by-100 reciprocal products, and the result register.
// Throughput: one item per cycle unless rsp_stall holds a waiting result; the remembered
// request is updated in the same cycle that its result enters the result register.
// The four thresholds and step percents are written through the csr_ port, which is always
// ready; write them only while no item is in flight.
// Reset (synchronous, active high) empties the pipeline, restores the register defaults
// (80, 35, 25, 5) and clears the remembered request, so the first step starts from the
// current frequency unless the policy minimum is zero.
// When rsp_stall holds a waiting result, earlier stages keep filling; req_stall rises only
// once every stage holds an item.
module step_frequency_governor_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sfg_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      sfg_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [6:0]       csr_data
);
   import sfg_pkg::*;

   // Configuration registers.
   logic [6:0] up_threshold_ff, up_threshold_in;
   logic [6:0] down_threshold_ff, down_threshold_in;
   logic [6:0] up_pct_ff, up_pct_in;
   logic [6:0] down_pct_ff, down_pct_in;

   // Stage one: the accepted item as it came in.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // Stage two: direction decided, percent products formed.
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_up_ff, s2_down_ff;
   logic [23:0] s2_min_ff, s2_max_ff, s2_now_ff;
   logic [30:0] s2_up_prod_ff, s2_down_prod_ff;

   // Stage three: steps scaled down by 100, ready for the state update.
   logic     s3_valid_ff, s3_valid_in;
   step_type s3_step_ff, s3_step_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type update_result;

   logic out_free, s3_emits, s3_leaves, emit;
   logic ready3, ready2, ready1, accept;
   logic [24:0] max_quot;

   assign csr_ready = 1'b1;

   always_comb begin
      up_threshold_in   = up_threshold_ff;
      down_threshold_in = down_threshold_ff;
      up_pct_in         = up_pct_ff;
      down_pct_in       = down_pct_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UP_THRESHOLD:      up_threshold_in   = csr_data;
            CSR_DOWN_THRESHOLD:    down_threshold_in = csr_data;
            CSR_UP_STEP_PERCENT:   up_pct_in         = csr_data;
            CSR_DOWN_STEP_PERCENT: down_pct_in       = csr_data;
            default:               up_threshold_in   = up_threshold_ff;
         endcase
      end
   end

   // Each stage moves forward when the stage after it is empty or is moving too.
   // An item that produces no result leaves stage three without using the result register.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s3_emits  = s3_step_ff.step_up || s3_step_ff.step_down;
      s3_leaves = s3_valid_ff && (!s3_emits || out_free);
      emit      = s3_valid_ff && s3_emits && out_free;
      ready3    = !s3_valid_ff || s3_leaves;
      ready2    = !s2_valid_ff || ready3;
      ready1    = !s1_valid_ff || ready2;
      accept    = req_valid && ready1;

      s1_valid_in  = ready1 ? req_valid : s1_valid_ff;
      s2_valid_in  = ready2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = ready3 ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   assign req_stall = !ready1;

   // Divide the stage-two products by 100.
   always_comb begin
      max_quot             = div100({7'd0, s2_max_ff});
      s3_step_in.step_up   = s2_up_ff;
      s3_step_in.step_down = s2_down_ff;
      s3_step_in.freq_min  = s2_min_ff;
      s3_step_in.freq_max  = s2_max_ff;
      s3_step_in.freq_now  = s2_now_ff;
      s3_step_in.up_step   = div100(s2_up_prod_ff);
      s3_step_in.down_step = div100(s2_down_prod_ff);
      s3_step_in.max_step  = max_quot[17:0];
   end

   sfg_update u_update (
      .clock  (clock),
      .reset  (reset),
      .step   (s3_step_ff),
      .commit (emit),
      .result (update_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         up_threshold_ff   <= RST_UP_THRESHOLD;
         down_threshold_ff <= RST_DOWN_THRESHOLD;
         up_pct_ff         <= RST_UP_STEP_PERCENT;
         down_pct_ff       <= RST_DOWN_STEP_PERCENT;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         up_threshold_ff   <= up_threshold_in;
         down_threshold_ff <= down_threshold_in;
         up_pct_ff         <= up_pct_in;
         down_pct_ff       <= down_pct_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         s3_valid_ff       <= s3_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (ready2) begin
         // Step up wins when both thresholds are met.
         s2_up_ff        <= s1_data_ff.load_percent > up_threshold_ff;
         s2_down_ff      <= !(s1_data_ff.load_percent > up_threshold_ff)
                            && (s1_data_ff.load_percent < down_threshold_ff);
         s2_min_ff       <= s1_data_ff.freq_min;
         s2_max_ff       <= s1_data_ff.freq_max;
         s2_now_ff       <= s1_data_ff.freq_now;
         s2_up_prod_ff   <= {24'd0, up_pct_ff} * {7'd0, s1_data_ff.freq_max};
         s2_down_prod_ff <= {24'd0, down_pct_ff} * {7'd0, s1_data_ff.freq_max};
      end
      if (ready3) begin
         s3_step_ff <= s3_step_in;
      end
      if (emit) begin
         rsp_data_ff <= update_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not enter the first stage");

   a_s3_holds : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_leaves |=> s3_valid_ff && $stable(s3_step_ff))
      else $error("blocked item in the update stage was lost or changed");

   a_emit_loads : assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && rsp_data_ff.round_up == $past(s3_step_ff.step_down))
      else $error("result register did not take the emitted item");

endmodule

`default_nettype wire

### hdl/sfg_update.sv
`default_nettype none

module sfg_update (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sfg_pkg::step_type step,
   input  wire logic             commit,
   output      sfg_pkg::rsp_type result
);
   import sfg_pkg::*;

   logic [23:0] last_request_ff;
   logic [23:0] last_request_in;
   logic [23:0] base;
   logic [25:0] up_sum;
   logic [23:0] up_target;
   logic [24:0] down_amount;
   logic [23:0] down_diff;
   logic [23:0] down_target;

   always_comb begin
      // A remembered request outside the policy range is replaced by the current frequency.
      if (last_request_ff > step.freq_max || last_request_ff < step.freq_min) begin
         base = step.freq_now;
      end else begin
         base = last_request_ff;
      end

      up_sum = {2'd0, base} + {1'b0, step.up_step};
      if (up_sum > {2'd0, step.freq_max}) begin
         up_target = step.freq_max;
      end else begin
         up_target = up_sum[23:0];
      end

      // A zero down step falls back to one percent of the maximum.
      if (step.down_step == '0) begin
         down_amount = {7'd0, step.max_step};
      end else begin
         down_amount = step.down_step;
      end
      if ({1'b0, base} > down_amount) begin
         down_diff = base - down_amount[23:0];
      end else begin
         down_diff = step.freq_min;
      end
      if (down_diff < step.freq_min) begin
         down_target = step.freq_min;
      end else begin
         down_target = down_diff;
      end

      if (step.step_up) begin
         result.target_freq = up_target;
         result.round_up    = 1'b0;
      end else begin
         result.target_freq = down_target;
         result.round_up    = 1'b1;
      end

      last_request_in = last_request_ff;
      if (commit) begin
         last_request_in = result.target_freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_request_ff <= '0;
      end else begin
         last_request_ff <= last_request_in;
      end
   end

   a_up_below_max : assert property (@(posedge clock) disable iff (reset)
      commit && step.step_up |-> result.target_freq <= step.freq_max)
      else $error("step up exceeded the policy maximum");

   a_down_above_min : assert property (@(posedge clock) disable iff (reset)
      commit && !step.step_up |-> result.target_freq >= step.freq_min)
      else $error("step down fell below the policy minimum");

   a_request_kept : assert property (@(posedge clock) disable iff (reset)
      commit |=> last_request_ff == $past(result.target_freq))
      else $error("emitted target was not remembered");

endmodule

`default_nettype wire
